// File: rtl/assert_macros.svh
// Assertion macros shared by the modules of the random range generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside of reset.
`define LRRG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition holds at every clock edge outside of reset.
`define LRRG_ASSERT_ALWAYS(label, cond, msg) \
  `LRRG_ASSERT(label, cond, msg)

`endif

// File: rtl/lrrg_pkg.sv
// Types, constants and the LFSR step function for the random range generator.
package lrrg_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned COUNT_BITS = $clog2(WORD_BITS);

  localparam logic [WORD_BITS-1:0] TAP_MASK = 32'hB400_0001;
  localparam logic [WORD_BITS-1:0] SEED_SUBST = 32'hDEAD_BEEF;

  localparam logic [1:0] FUNC_RAW = 2'd0;
  localparam logic [1:0] FUNC_BELOW = 2'd1;
  localparam logic [1:0] FUNC_RANGE = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic special;
  } sts_t;

  function automatic logic [WORD_BITS-1:0] lfsr_advance(input logic [WORD_BITS-1:0] s);
    logic [WORD_BITS-1:0] shifted;
    shifted = s >> 1;
    lfsr_advance = s[0] ? (shifted ^ TAP_MASK) : shifted;
  endfunction

endpackage

// File: rtl/lrrg_ctrl.sv
// Controller state machine that sequences the load, the 32 steps and the output write.
`include "assert_macros.svh"

module lrrg_ctrl
  import lrrg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic out_valid_next;

  always_comb begin
    state_next = state;
    count_next = count;
    out_valid_next = out_valid;
    cmd = '0;
    in_ready = 1'b0;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          count_next = '0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.special) begin
          state_next = S_FINISH;
        end else begin
          cmd.step = 1'b1;
          count_next = count + 1'b1;
          if (count == COUNT_BITS'(WORD_BITS - 1)) begin
            state_next = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.write_out = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      out_valid <= out_valid_next;
    end
  end

  `LRRG_ASSERT(a_write_free, cmd.write_out |-> (!out_valid || out_ready),
    "Output word overwritten before it was taken.")
  `LRRG_ASSERT(a_valid_from_finish, $rose(out_valid) |-> $past(state == S_FINISH),
    "Output word appeared without a finished request.")

endmodule

// File: rtl/lrrg_dp.sv
// Datapath with the LFSR, the bit-serial restoring divider and the output register.
`include "assert_macros.svh"

module lrrg_dp
  import lrrg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [WORD_BITS-1:0] cfg_wdata,
  input  logic [1:0]           func,
  input  logic [WORD_BITS-1:0] lower_bound,
  input  logic [WORD_BITS-1:0] upper_bound,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic [WORD_BITS-1:0] value
);

  logic [WORD_BITS-1:0] lfsr;
  logic [WORD_BITS-1:0] lfsr_next;
  logic [1:0]           op;
  logic                 special;
  logic [WORD_BITS-1:0] lo;
  logic [WORD_BITS-1:0] divisor;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] span;
  logic                 in_special;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0] result;

  assign lfsr_next = lfsr_advance(lfsr);
  assign span = upper_bound - lower_bound + 1'b1;
  assign trial = {rem, lfsr_next[0]};
  assign diff = trial - {1'b0, divisor};

  always_comb begin
    case (func)
      FUNC_RAW:   in_special = 1'b0;
      FUNC_BELOW: in_special = (upper_bound == '0);
      FUNC_RANGE: in_special = (lower_bound > upper_bound) || (span == '0);
      default:    in_special = 1'b1;
    endcase
  end

  always_comb begin
    case (op)
      FUNC_RAW:   result = special ? '0 : acc;
      FUNC_BELOW: result = special ? '0 : rem;
      FUNC_RANGE: result = special ? lo : lo + rem;
      default:    result = '0;
    endcase
  end

  assign sts.special = special;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= SEED_SUBST;
      op <= FUNC_RAW;
      special <= 1'b0;
    end else begin
      if (cfg_we) begin
        lfsr <= (cfg_wdata == '0) ? SEED_SUBST : cfg_wdata;
      end else if (cmd.step) begin
        lfsr <= lfsr_next;
      end
      if (cmd.load) begin
        op <= func;
        special <= in_special;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo <= lower_bound;
      divisor <= (func == FUNC_RANGE) ? span : upper_bound;
      rem <= '0;
      acc <= '0;
    end else if (cmd.step) begin
      acc <= {acc[WORD_BITS-2:0], lfsr_next[0]};
      rem <= diff[WORD_BITS] ? trial[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
    end
    if (cmd.write_out) begin
      value <= result;
    end
  end

  `LRRG_ASSERT_ALWAYS(a_lfsr_nonzero, lfsr != '0, "LFSR reached the all-zero state.")
  `LRRG_ASSERT(a_rem_below, (!special && op != FUNC_RAW && !cmd.load) |-> (rem < divisor),
    "Divider remainder is not below the divisor.")

endmodule

// File: rtl/lfsr_random_range_generator_core.sv
// Top level of the LFSR random range generator: controller and datapath.
//
//   channel   signals                                               direction
//   request   in_valid in_ready func lower_bound upper_bound        in
//   result    out_valid out_ready value                             out
//   config    cfg_we cfg_wdata                                      in
//
// A request runs from acceptance to the result word in order: a load, then
// 32 steps of the LFSR with one restoring division step each, then a write of
// the output register. Requests that need no draw skip the steps.
// A configuration write loads the LFSR at once; reset loads 0xDEADBEEF.
// A result waiting on out_ready holds the next request in the final state.
module lfsr_random_range_generator_core
  import lrrg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [WORD_BITS-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [WORD_BITS-1:0] lower_bound,
  input  logic [WORD_BITS-1:0] upper_bound,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] value
);

  cmd_t cmd;
  sts_t sts;

  lrrg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrrg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .func        (func),
    .lower_bound (lower_bound),
    .upper_bound (upper_bound),
    .cmd         (cmd),
    .sts         (sts),
    .value       (value)
  );

endmodule

// File: tb/tb_lfsr_random_range_generator_core.sv
// Testbench for the LFSR random range generator core, checked against its own LFSR predictor.
`timescale 1ns / 100ps

module tb_lfsr_random_range_generator_core;
  import lrrg_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_WORDS = 300;

  typedef struct packed {
    logic [1:0]           op;
    logic [WORD_BITS-1:0] lo;
    logic [WORD_BITS-1:0] hi;
    logic                 fixed;
    logic [WORD_BITS-1:0] want;
  } directed_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [WORD_BITS-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           func = FUNC_RAW;
  logic [WORD_BITS-1:0] lower_bound = '0;
  logic [WORD_BITS-1:0] upper_bound = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_BITS-1:0] value;

  logic [WORD_BITS-1:0] lfsr_shadow;
  logic [WORD_BITS-1:0] expected_values[$];
  logic [WORD_BITS-1:0] rx_want;
  directed_word_t       directed_words[$];
  int                   errors = 0;
  int                   idle_cycles = 0;
  int                   rx_hold = 0;
  bit                   rx_steady = 1'b0;
  bit                   tx_steady = 1'b0;

  lfsr_random_range_generator_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .lower_bound (lower_bound),
    .upper_bound (upper_bound),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value)
  );

  always #6 clk = ~clk;

  function automatic void load_seed_shadow(input logic [WORD_BITS-1:0] s);
    lfsr_shadow = (s == '0) ? SEED_SUBST : s;
  endfunction

  function automatic logic [WORD_BITS-1:0] draw_raw_word();
    logic [WORD_BITS-1:0] acc;
    acc = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (lfsr_shadow[0]) begin
        lfsr_shadow = (lfsr_shadow >> 1) ^ TAP_MASK;
      end else begin
        lfsr_shadow = lfsr_shadow >> 1;
      end
      acc = {acc[WORD_BITS-2:0], lfsr_shadow[0]};
    end
    return acc;
  endfunction

  function automatic logic [WORD_BITS-1:0] draw_below(input logic [WORD_BITS-1:0] bound);
    if (bound == '0) return '0;
    return draw_raw_word() % bound;
  endfunction

  function automatic logic [WORD_BITS-1:0] predict_value(input logic [1:0] op,
                                                        input logic [WORD_BITS-1:0] lo,
                                                        input logic [WORD_BITS-1:0] hi);
    logic [WORD_BITS-1:0] span;
    span = hi - lo + 32'd1;
    case (op)
      FUNC_RAW: begin
        return draw_raw_word();
      end
      FUNC_BELOW: begin
        return draw_below(hi);
      end
      FUNC_RANGE: begin
        if (lo > hi) return lo;
        return lo + draw_below(span);
      end
      default: begin
        return '0;
      end
    endcase
  endfunction

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [WORD_BITS-1:0] random_bound();
    case ($urandom_range(5))
      0: begin
        return $urandom_range(16);
      end
      1: begin
        return 32'h1 << $urandom_range(31);
      end
      2: begin
        return (32'h1 << $urandom_range(31)) - 32'h1;
      end
      3: begin
        return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      end
      default: begin
        return $urandom();
      end
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [WORD_BITS-1:0] lo,
                           input logic [WORD_BITS-1:0] hi, input logic fixed,
                           input logic [WORD_BITS-1:0] want);
    int gap;
    logic [WORD_BITS-1:0] predicted;
    if ($urandom_range(49) == 0) tx_steady = !tx_steady;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    lower_bound <= lo;
    upper_bound <= hi;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = predict_value(op, lo, hi);
    expected_values.push_back(fixed ? want : predicted);
  endtask

  task automatic send_random_word();
    logic [1:0] op;
    logic [WORD_BITS-1:0] lo;
    logic [WORD_BITS-1:0] hi;
    int r;
    r = $urandom_range(99);
    lo = $urandom();
    hi = random_bound();
    if (r < 25) begin
      op = FUNC_RAW;
    end else if (r < 55) begin
      op = FUNC_BELOW;
    end else if (r < 95) begin
      op = FUNC_RANGE;
    end else begin
      op = FUNC_UNUSED;
    end
    if (op == FUNC_RANGE) begin
      case ($urandom_range(9))
        0: begin
          hi = $urandom();
        end
        1: begin
          lo = '0;
          hi = 32'hFFFF_FFFF;
        end
        default: begin
          lo = $urandom_range(1) ? $urandom() : random_bound();
          hi = lo + random_bound();
          if (hi < lo) hi = 32'hFFFF_FFFF;
        end
      endcase
    end
    send_word(op, lo, hi, 1'b0, '0);
  endtask

  task automatic write_seed(input logic [WORD_BITS-1:0] s);
    while (expected_values.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    load_seed_shadow(s);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h", $time, value);
        errors++;
      end else begin
        rx_want = expected_values.pop_front();
        if (value !== rx_want) begin
          $display("%0t: value mismatch: expected %h, actual %h", $time, rx_want, value);
          errors++;
        end
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(99) < 3) rx_steady = !rx_steady;
      if (!rx_steady && $urandom_range(99) < 30) rx_hold = pick_gap(1'b0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_lfsr_random_range_generator_core failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [WORD_BITS-1:0] seed;
    load_seed_shadow(SEED_SUBST);

    // Rows with a fixed word are the cases that need no draw or map into a single value.
    directed_words.push_back('{FUNC_RAW,    32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0});
    directed_words.push_back('{FUNC_RAW,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0});
    directed_words.push_back('{FUNC_BELOW,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0});
    directed_words.push_back('{FUNC_BELOW,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0});
    directed_words.push_back('{FUNC_BELOW,  32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0});
    directed_words.push_back('{FUNC_BELOW,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0});
    directed_words.push_back('{FUNC_BELOW,  32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0});
    directed_words.push_back('{FUNC_BELOW,  32'hFFFF_FFFF, 32'h0000_0007, 1'b0, 32'h0});
    directed_words.push_back('{FUNC_RANGE,  32'h0000_0005, 32'h0000_0004, 1'b1, 32'h5});
    directed_words.push_back('{FUNC_RANGE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                               32'hFFFF_FFFF});
    directed_words.push_back('{FUNC_RANGE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0});
    directed_words.push_back('{FUNC_RANGE,  32'h0000_0000, 32'hFFFF_FFFE, 1'b0, 32'h0});
    directed_words.push_back('{FUNC_RANGE,  32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0});
    directed_words.push_back('{FUNC_RANGE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                               32'hFFFF_FFFF});
    directed_words.push_back('{FUNC_RANGE,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0});
    directed_words.push_back('{FUNC_RANGE,  32'h0000_0064, 32'h0000_006D, 1'b0, 32'h0});
    directed_words.push_back('{FUNC_RANGE,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0});
    directed_words.push_back('{FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0});
    directed_words.push_back('{FUNC_UNUSED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0});
    directed_words.push_back('{FUNC_RAW,    32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0});
    directed_words.push_back('{FUNC_BELOW,  32'h0000_0000, 32'h0000_0003, 1'b0, 32'h0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_words[i]) begin
      send_word(directed_words[i].op, directed_words[i].lo, directed_words[i].hi,
                directed_words[i].fixed, directed_words[i].want);
    end
    in_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          seed = 32'h0000_0000;
        end
        1: begin
          seed = 32'h0000_0001;
        end
        2: begin
          seed = 32'hFFFF_FFFF;
        end
        3: begin
          seed = 32'h8000_0000;
        end
        default: begin
          seed = $urandom();
        end
      endcase
      write_seed(seed);
      repeat (PHASE_WORDS) send_random_word();
      in_valid <= 1'b0;
    end

    while (expected_values.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_lfsr_random_range_generator_core passed");
    end else begin
      $display("tb_lfsr_random_range_generator_core failed");
    end
    $finish;
  end

endmodule
